/* src/dkvt_pkg.sv */
// ----------------------------------------------------------------------------
// dkvt_pkg
// Shared sizes, codes, types and helpers of the dual-key versioned table.
// ----------------------------------------------------------------------------
package dkvt_pkg;

  // Table geometry; slot hashing takes the low key bits, so SLOTS is a power of two
  localparam int SLOTS = 16;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int PTR_W = IDX_W + 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  // Field widths
  localparam int KIND_W   = 2;
  localparam int KEY_W    = 15;
  localparam int VER_W    = 5;
  localparam int PAY_W    = 32;
  localparam int STATUS_W = 2;

  // Null chain pointer
  localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(SLOTS);

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIND   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_LIVE  = 2'd1,
    MARK_GONE  = 2'd2
  } mark_t;

  // One stored entry as seen on the read port
  typedef struct packed {
    mark_t             mark;
    logic [KEY_W-1:0]  first_key;
    logic [KEY_W-1:0]  second_key;
    logic [VER_W-1:0]  first_version;
    logic [VER_W-1:0]  second_version;
    logic [PAY_W-1:0]  payload;
    logic [PTR_W-1:0]  link;
  } entry_t;

  // Write commands from the sequencer to the store
  typedef struct packed {
    logic              ent_en;
    logic [IDX_W-1:0]  ent_slot;
    logic [KEY_W-1:0]  first_key;
    logic [KEY_W-1:0]  second_key;
    logic [VER_W-1:0]  first_version;
    logic [VER_W-1:0]  second_version;
    logic [PAY_W-1:0]  payload;
    logic              link_en;
    logic [IDX_W-1:0]  link_slot;
    logic [PTR_W-1:0]  link_val;
    logic              head_en;
    logic [IDX_W-1:0]  head_idx;
    logic [PTR_W-1:0]  head_val;
    logic              mark_en;
    logic [IDX_W-1:0]  mark_slot;
    mark_t             mark_val;
  } store_wr_t;

  // Non-negative remainder of a key modulo SLOTS
  function automatic logic [IDX_W-1:0] hash_key(input logic [KEY_W-1:0] key);
    return key[IDX_W-1:0];
  endfunction

endpackage

/* src/dkvt_if.sv */
// ----------------------------------------------------------------------------
// dkvt_req_if / dkvt_rsp_if
// Valid/ready channels for operation requests and result rows.
// ----------------------------------------------------------------------------
interface dkvt_req_if import dkvt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [KEY_W-1:0]    first_key;
  logic [KEY_W-1:0]    second_key;
  logic [PAY_W-1:0]    payload;
  logic [KEY_W-1:0]    lookup_key;
  logic                key_space;
  logic                delete_one;
  logic [VER_W-1:0]    version_wanted;

  modport source (output valid, kind, first_key, second_key, payload, lookup_key,
                  key_space, delete_one, version_wanted, input ready);
  modport sink (input valid, kind, first_key, second_key, payload, lookup_key,
                key_space, delete_one, version_wanted, output ready);
endinterface

interface dkvt_rsp_if import dkvt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    out_first_key;
  logic [VER_W-1:0]    out_first_version;
  logic [KEY_W-1:0]    out_second_key;
  logic [VER_W-1:0]    out_second_version;
  logic [PAY_W-1:0]    out_payload;
  logic [IDX_W-1:0]    out_probe_slot;
  logic [IDX_W-1:0]    out_chain_slot;
  logic                last;

  modport source (output valid, status, out_first_key, out_first_version,
                  out_second_key, out_second_version, out_payload,
                  out_probe_slot, out_chain_slot, last, input ready);
  modport sink (input valid, status, out_first_key, out_first_version,
                out_second_key, out_second_version, out_payload,
                out_probe_slot, out_chain_slot, last, output ready);
endinterface

/* src/dkvt_store.sv */
// ----------------------------------------------------------------------------
// dkvt_store
// Entry storage: slot marks, entry fields, chain links and chain heads.
// ----------------------------------------------------------------------------
module dkvt_store import dkvt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] rd_slot,
  output entry_t           rd_entry,
  input  logic [IDX_W-1:0] head_idx,
  output logic [PTR_W-1:0] head_ptr,
  input  store_wr_t        wr
);

  mark_t            mark       [SLOTS];
  logic [KEY_W-1:0] first_key  [SLOTS];
  logic [KEY_W-1:0] second_key [SLOTS];
  logic [VER_W-1:0] first_ver  [SLOTS];
  logic [VER_W-1:0] second_ver [SLOTS];
  logic [PAY_W-1:0] payload    [SLOTS];
  logic [PTR_W-1:0] link       [SLOTS];
  logic [PTR_W-1:0] head       [SLOTS];

  // Clear marks and chain heads, update on command
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        mark[i] <= MARK_EMPTY;
        head[i] <= NIL_PTR;
      end
    end else begin
      if (wr.mark_en) mark[wr.mark_slot] <= wr.mark_val;
      if (wr.head_en) head[wr.head_idx] <= wr.head_val;
    end
  end

  // Entry fields and links carry no reset
  always_ff @(posedge clk) begin
    if (wr.ent_en) begin
      first_key[wr.ent_slot]  <= wr.first_key;
      second_key[wr.ent_slot] <= wr.second_key;
      first_ver[wr.ent_slot]  <= wr.first_version;
      second_ver[wr.ent_slot] <= wr.second_version;
      payload[wr.ent_slot]    <= wr.payload;
    end
    if (wr.link_en) link[wr.link_slot] <= wr.link_val;
  end

  // Read port
  always_comb begin
    rd_entry.mark           = mark[rd_slot];
    rd_entry.first_key      = first_key[rd_slot];
    rd_entry.second_key     = second_key[rd_slot];
    rd_entry.first_version  = first_ver[rd_slot];
    rd_entry.second_version = second_ver[rd_slot];
    rd_entry.payload        = payload[rd_slot];
    rd_entry.link           = link[rd_slot];
  end

  assign head_ptr = head[head_idx];

endmodule

/* src/dual_key_versioned_table.sv */
// Insert walks the probe run, then the second-key chain; find walks the probe run
// or the chain, then reports each match as a row; delete walks, then checks each
// match and walks the chain for the parent of each removal not at the chain head.
// One operation at a time: the next request is taken after the last result row.
// The walks run serially over the single store entry read port.
// Reset (rst, synchronous): table empty, all chains null, no pending result.
// ----------------------------------------------------------------------------
// dual_key_versioned_table
// Two-key table: probed first-key slots, chained second keys, with versions.
// ----------------------------------------------------------------------------
module dual_key_versioned_table import dkvt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  dkvt_req_if.sink    req,
  dkvt_rsp_if.source  rsp
);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_PROBE   = 10'b0000000010,
    S_CHAIN   = 10'b0000000100,
    S_WRITE   = 10'b0000001000,
    S_HEAD    = 10'b0000010000,
    S_COLLECT = 10'b0000100000,
    S_EMIT    = 10'b0001000000,
    S_DCHK    = 10'b0010000000,
    S_UNLINK  = 10'b0100000000,
    S_ROW     = 10'b1000000000
  } state_t;

  state_t state, after_row;

  // Latched request
  logic [KIND_W-1:0] kind;
  logic [KEY_W-1:0]  fkey, skey, lkey;
  logic [PAY_W-1:0]  pay;
  logic              space, one;
  logic [VER_W-1:0]  want;

  // Walk state
  logic [CNT_W-1:0]  live;
  logic [PTR_W-1:0]  ptr, place;
  logic [CNT_W-1:0]  step, n, idx;
  logic [VER_W-1:0]  v1, v2;
  logic [IDX_W-1:0]  list [SLOTS];
  logic              removed;
  logic [IDX_W-1:0]  target;
  logic [PTR_W-1:0]  tlink;

  // Pending result row
  logic [STATUS_W-1:0] row_status;
  logic [IDX_W-1:0]    row_slot;
  logic                row_ent, row_last;

  // Output register
  logic                ovalid;
  logic [STATUS_W-1:0] o_status;
  logic [KEY_W-1:0]    o_fk, o_sk;
  logic [VER_W-1:0]    o_fv, o_sv;
  logic [PAY_W-1:0]    o_pay;
  logic [IDX_W-1:0]    o_ps, o_cs;
  logic                o_last;

  // Store port
  logic [IDX_W-1:0] rd_slot, head_idx;
  entry_t           rd;
  logic [PTR_W-1:0] head_ptr;
  store_wr_t        wr;

  dkvt_store u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_slot  (rd_slot),
    .rd_entry (rd),
    .head_idx (head_idx),
    .head_ptr (head_ptr),
    .wr       (wr)
  );

  logic [IDX_W-1:0] sel_slot, emit_slot;
  logic [CNT_W-1:0] rev_idx;
  logic [VER_W-1:0] dver;
  logic [PTR_W-1:0] place_n;
  logic             oload;

  assign rev_idx   = n - idx - CNT_W'(1);
  assign sel_slot  = list[idx[IDX_W-1:0]];
  assign emit_slot = space ? list[rev_idx[IDX_W-1:0]] : sel_slot;
  assign dver      = space ? rd.second_version : rd.first_version;
  assign oload     = (state == S_ROW) && (!ovalid || rsp.ready);
  assign req.ready = (state == S_IDLE);

  // First free slot seen in the probe run
  always_comb begin
    place_n = place;
    if (place == NIL_PTR && rd.mark != MARK_LIVE) place_n = ptr;
  end

  // Select read addresses
  always_comb begin
    rd_slot  = ptr[IDX_W-1:0];
    head_idx = hash_key(skey);
    unique case (state)
      S_HEAD:  head_idx = hash_key(lkey);
      S_DCHK: begin
        rd_slot  = sel_slot;
        head_idx = hash_key(rd.second_key);
      end
      S_ROW:   rd_slot = row_slot;
      default: ;
    endcase
  end

  // Store write commands
  always_comb begin
    wr = '0;
    wr.ent_slot       = place[IDX_W-1:0];
    wr.first_key      = fkey;
    wr.second_key     = skey;
    wr.first_version  = v1;
    wr.second_version = v2;
    wr.payload        = pay;
    wr.mark_val       = MARK_LIVE;
    unique case (state)
      S_WRITE: begin
        wr.ent_en    = 1'b1;
        wr.link_en   = 1'b1;
        wr.link_slot = place[IDX_W-1:0];
        wr.link_val  = head_ptr;
        wr.head_en   = 1'b1;
        wr.head_idx  = hash_key(skey);
        wr.head_val  = place;
        wr.mark_en   = 1'b1;
        wr.mark_slot = place[IDX_W-1:0];
      end
      S_DCHK: begin
        if (idx != n && !(one && dver != want)) begin
          wr.mark_en   = 1'b1;
          wr.mark_slot = sel_slot;
          wr.mark_val  = MARK_GONE;
          if (head_ptr == {1'b0, sel_slot}) begin
            wr.head_en  = 1'b1;
            wr.head_idx = hash_key(rd.second_key);
            wr.head_val = rd.link;
          end
        end
      end
      S_UNLINK: begin
        if (ptr != NIL_PTR && step != CNT_W'(SLOTS) && rd.link == {1'b0, target}) begin
          wr.link_en   = 1'b1;
          wr.link_slot = ptr[IDX_W-1:0];
          wr.link_val  = tlink;
        end
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      live  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            kind  <= req.kind;
            fkey  <= req.first_key;
            skey  <= req.second_key;
            pay   <= req.payload;
            lkey  <= req.lookup_key;
            space <= req.key_space;
            one   <= req.delete_one;
            want  <= req.version_wanted;
            step  <= '0;
            n     <= '0;
            idx   <= '0;
            removed   <= 1'b0;
            row_ent   <= 1'b0;
            row_last  <= 1'b1;
            after_row <= S_IDLE;
            if (req.kind == KIND_INSERT) begin
              if (live == CNT_W'(SLOTS)) begin
                row_status <= ST_FULL;
                state      <= S_ROW;
              end else begin
                ptr   <= {1'b0, hash_key(req.first_key)};
                place <= NIL_PTR;
                v1    <= '0;
                state <= S_PROBE;
              end
            end else if (req.kind == KIND_FIND || req.kind == KIND_DELETE) begin
              if (live == '0) begin
                row_status <= ST_EMPTY;
                state      <= S_ROW;
              end else begin
                state <= S_HEAD;
              end
            end
          end
        end

        // Walk the probe run for a free slot and the first-key version
        S_PROBE: begin
          place <= place_n;
          if (rd.mark == MARK_LIVE && rd.first_key == fkey) v1 <= v1 + VER_W'(1);
          ptr  <= {1'b0, ptr[IDX_W-1:0] + IDX_W'(1)};
          step <= step + CNT_W'(1);
          if (rd.mark == MARK_EMPTY || step == CNT_W'(SLOTS - 1)) begin
            if (place_n == NIL_PTR) begin
              row_status <= ST_FULL;
              state      <= S_ROW;
            end else begin
              ptr   <= head_ptr;
              step  <= '0;
              v2    <= '0;
              state <= S_CHAIN;
            end
          end
        end

        // Count same second keys on the chain
        S_CHAIN: begin
          if (ptr == NIL_PTR || step == CNT_W'(SLOTS)) begin
            state <= S_WRITE;
          end else begin
            if (rd.second_key == skey) v2 <= v2 + VER_W'(1);
            ptr  <= rd.link;
            step <= step + CNT_W'(1);
          end
        end

        S_WRITE: begin
          live       <= live + CNT_W'(1);
          row_status <= ST_OK;
          row_slot   <= place[IDX_W-1:0];
          row_ent    <= 1'b1;
          state      <= S_ROW;
        end

        S_HEAD: begin
          ptr   <= space ? head_ptr : {1'b0, hash_key(lkey)};
          state <= S_COLLECT;
        end

        // Gather matching slots in walk order
        S_COLLECT: begin
          if (step == CNT_W'(SLOTS) || (space && ptr == NIL_PTR) ||
              (!space && rd.mark == MARK_EMPTY)) begin
            if (kind == KIND_DELETE) begin
              state <= S_DCHK;
            end else if (n == '0) begin
              row_status <= ST_NOT_FOUND;
              state      <= S_ROW;
            end else begin
              state <= S_EMIT;
            end
          end else begin
            if (rd.mark == MARK_LIVE &&
                (space ? rd.second_key == lkey : rd.first_key == lkey)) begin
              list[n[IDX_W-1:0]] <= ptr[IDX_W-1:0];
              n <= n + CNT_W'(1);
            end
            ptr  <= space ? rd.link : {1'b0, ptr[IDX_W-1:0] + IDX_W'(1)};
            step <= step + CNT_W'(1);
          end
        end

        S_EMIT: begin
          row_status <= ST_OK;
          row_slot   <= emit_slot;
          row_ent    <= 1'b1;
          row_last   <= (idx + CNT_W'(1) == n);
          after_row  <= (idx + CNT_W'(1) == n) ? S_IDLE : S_EMIT;
          idx        <= idx + CNT_W'(1);
          state      <= S_ROW;
        end

        // Remove matches; unlink from the chain head here or walk for the parent
        S_DCHK: begin
          if (idx == n) begin
            row_status <= removed ? ST_OK : ST_NOT_FOUND;
            state      <= S_ROW;
          end else if (one && dver != want) begin
            idx <= idx + CNT_W'(1);
          end else begin
            live    <= live - CNT_W'(1);
            removed <= 1'b1;
            target  <= sel_slot;
            tlink   <= rd.link;
            idx     <= one ? n : idx + CNT_W'(1);
            if (head_ptr != {1'b0, sel_slot}) begin
              ptr   <= head_ptr;
              step  <= '0;
              state <= S_UNLINK;
            end
          end
        end

        S_UNLINK: begin
          if (ptr == NIL_PTR || step == CNT_W'(SLOTS) || rd.link == {1'b0, target}) begin
            state <= S_DCHK;
          end else begin
            ptr  <= rd.link;
            step <= step + CNT_W'(1);
          end
        end

        S_ROW: begin
          if (oload) state <= after_row;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: load a row, drop it on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (oload) begin
      ovalid <= 1'b1;
    end else if (rsp.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (oload) begin
      o_status <= row_status;
      o_last   <= row_last;
      o_fk     <= row_ent ? rd.first_key : '0;
      o_fv     <= row_ent ? rd.first_version : '0;
      o_sk     <= row_ent ? rd.second_key : '0;
      o_sv     <= row_ent ? rd.second_version : '0;
      o_pay    <= row_ent ? rd.payload : '0;
      o_ps     <= row_ent ? row_slot : '0;
      o_cs     <= row_ent ? hash_key(rd.second_key) : '0;
    end
  end

  assign rsp.valid              = ovalid;
  assign rsp.status             = o_status;
  assign rsp.out_first_key      = o_fk;
  assign rsp.out_first_version  = o_fv;
  assign rsp.out_second_key     = o_sk;
  assign rsp.out_second_version = o_sv;
  assign rsp.out_payload        = o_pay;
  assign rsp.out_probe_slot     = o_ps;
  assign rsp.out_chain_slot     = o_cs;
  assign rsp.last               = o_last;

endmodule

/* test/dual_key_versioned_table_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_key_versioned_table_tb
// Drives insert, find and delete operations into the dual-key table, keeps a
// shadow copy of the probed slots and second-key chains, and compares every
// result row with the rows that the shadow table predicts.
// ----------------------------------------------------------------------------
module dual_key_versioned_table_tb;
  import dkvt_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;

  // Opcode that the block ignores
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  first_key;
    logic [KEY_W-1:0]  second_key;
    logic [PAY_W-1:0]  payload;
    logic [KEY_W-1:0]  lookup_key;
    logic              key_space;
    logic              delete_one;
    logic [VER_W-1:0]  version_wanted;
  } op_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    first_key;
    logic [VER_W-1:0]    first_version;
    logic [KEY_W-1:0]    second_key;
    logic [VER_W-1:0]    second_version;
    logic [PAY_W-1:0]    payload;
    logic [IDX_W-1:0]    probe_slot;
    logic [IDX_W-1:0]    chain_slot;
    logic                last;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dkvt_req_if req ();
  dkvt_rsp_if rsp ();

  dual_key_versioned_table DUT (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always #6 clk = ~clk;

  // Shadow table
  mark_t            sh_mark  [SLOTS];
  logic [KEY_W-1:0] sh_fkey  [SLOTS];
  logic [KEY_W-1:0] sh_skey  [SLOTS];
  logic [VER_W-1:0] sh_fver  [SLOTS];
  logic [VER_W-1:0] sh_sver  [SLOTS];
  logic [PAY_W-1:0] sh_pay   [SLOTS];
  int               sh_link  [SLOTS];
  int               sh_head  [SLOTS];
  int               sh_live;

  row_t pending_rows[$];
  int   errors = 0;
  int   idle_cycles = 0;
  bit   hold_request = 0;

  logic [KEY_W-1:0] key_pool[8] = '{15'd3, 15'd19, -15'sd13, 15'd5,
                                    -15'sd10000, 15'd9999, 15'd35, -15'sd1};

  function automatic row_t entry_row(logic [STATUS_W-1:0] st, int s, logic lst);
    row_t r;
    r = '{default: '0};
    r.status = st;
    r.last = lst;
    if (s >= 0) begin
      r.first_key = sh_fkey[s];
      r.first_version = sh_fver[s];
      r.second_key = sh_skey[s];
      r.second_version = sh_sver[s];
      r.payload = sh_pay[s];
      r.probe_slot = IDX_W'(s);
      r.chain_slot = sh_skey[s][IDX_W-1:0];
    end
    return r;
  endfunction

  // Matching live slots: probe order, or chain order newest first
  function automatic void gather_matches(logic space, logic [KEY_W-1:0] key,
                                         ref int hits[$]);
    int s;
    hits.delete();
    if (!space) begin
      s = key[IDX_W-1:0];
      for (int i = 0; i < SLOTS; i++) begin
        if (sh_mark[s] == MARK_EMPTY) break;
        if (sh_mark[s] == MARK_LIVE && sh_fkey[s] == key) hits.push_back(s);
        s = (s + 1) % SLOTS;
      end
    end else begin
      s = sh_head[key[IDX_W-1:0]];
      for (int i = 0; i < SLOTS && s < SLOTS; i++) begin
        if (sh_mark[s] == MARK_LIVE && sh_skey[s] == key) hits.push_back(s);
        s = sh_link[s];
      end
    end
  endfunction

  function automatic void unlink_slot(int s);
    int c;
    int p;
    c = sh_skey[s][IDX_W-1:0];
    sh_mark[s] = MARK_GONE;
    if (sh_head[c] == s) begin
      sh_head[c] = sh_link[s];
    end else begin
      p = sh_head[c];
      for (int i = 0; i < SLOTS && p < SLOTS; i++) begin
        if (sh_link[p] == s) begin
          sh_link[p] = sh_link[s];
          break;
        end
        p = sh_link[p];
      end
    end
    if (sh_live > 0) sh_live--;
  endfunction

  // Update the shadow table and queue the rows one operation produces
  function automatic void predict_rows(op_t op);
    int hits[$];
    int s;
    int place;
    int v1;
    int v2;
    int c;
    int removed;
    case (op.kind)
      KIND_INSERT: begin
        place = -1;
        v1 = 0;
        s = op.first_key[IDX_W-1:0];
        if (sh_live < SLOTS) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (sh_mark[s] == MARK_EMPTY) begin
              if (place < 0) place = s;
              break;
            end
            if (sh_mark[s] == MARK_GONE) begin
              if (place < 0) place = s;
            end else if (sh_fkey[s] == op.first_key) begin
              v1++;
            end
            s = (s + 1) % SLOTS;
          end
        end
        if (place < 0) begin
          pending_rows.push_back(entry_row(ST_FULL, -1, 1'b1));
        end else begin
          c = op.second_key[IDX_W-1:0];
          v2 = 0;
          s = sh_head[c];
          for (int i = 0; i < SLOTS && s < SLOTS; i++) begin
            if (sh_skey[s] == op.second_key) v2++;
            s = sh_link[s];
          end
          sh_fkey[place] = op.first_key;
          sh_skey[place] = op.second_key;
          sh_fver[place] = VER_W'(v1);
          sh_sver[place] = VER_W'(v2);
          sh_pay[place] = op.payload;
          sh_link[place] = sh_head[c];
          sh_head[c] = place;
          sh_mark[place] = MARK_LIVE;
          sh_live++;
          pending_rows.push_back(entry_row(ST_OK, place, 1'b1));
        end
      end
      KIND_FIND: begin
        if (sh_live == 0) begin
          pending_rows.push_back(entry_row(ST_EMPTY, -1, 1'b1));
        end else begin
          gather_matches(op.key_space, op.lookup_key, hits);
          if (hits.size() == 0) pending_rows.push_back(entry_row(ST_NOT_FOUND, -1, 1'b1));
          // chain matches are reported oldest first
          for (int i = 0; i < hits.size(); i++) begin
            s = op.key_space ? hits[hits.size() - 1 - i] : hits[i];
            pending_rows.push_back(entry_row(ST_OK, s, i + 1 == hits.size()));
          end
        end
      end
      KIND_DELETE: begin
        if (sh_live == 0) begin
          pending_rows.push_back(entry_row(ST_EMPTY, -1, 1'b1));
        end else begin
          gather_matches(op.key_space, op.lookup_key, hits);
          removed = 0;
          foreach (hits[i]) begin
            s = hits[i];
            v1 = op.key_space ? sh_sver[s] : sh_fver[s];
            if (op.delete_one && v1 != op.version_wanted) continue;
            unlink_slot(s);
            removed++;
            if (op.delete_one) break;
          end
          pending_rows.push_back(entry_row(removed ? ST_OK : ST_NOT_FOUND, -1, 1'b1));
        end
      end
      default: ;
    endcase
  endfunction

  // Offer one operation after a random gap and predict it at the transfer
  task automatic send_op(op_t op);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.kind <= op.kind;
    req.first_key <= op.first_key;
    req.second_key <= op.second_key;
    req.payload <= op.payload;
    req.lookup_key <= op.lookup_key;
    req.key_space <= op.key_space;
    req.delete_one <= op.delete_one;
    req.version_wanted <= op.version_wanted;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predict_rows(op);
  endtask

  function automatic op_t make_op(logic [KIND_W-1:0] k, logic [KEY_W-1:0] a,
                                  logic [KEY_W-1:0] b, logic [PAY_W-1:0] p,
                                  logic sp, logic one, logic [VER_W-1:0] v);
    op_t op;
    op.kind = k;
    op.first_key = a;
    op.second_key = b;
    op.payload = p;
    op.lookup_key = a;
    op.key_space = sp;
    op.delete_one = one;
    op.version_wanted = v;
    return op;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) == 0) return KEY_W'($urandom);
    return key_pool[$urandom_range(0, 7)];
  endfunction

  function automatic op_t random_op();
    op_t op;
    int w;
    w = $urandom_range(0, 99);
    op.kind = (w < 45) ? KIND_INSERT : (w < 72) ? KIND_FIND :
              (w < 98) ? KIND_DELETE : KIND_UNUSED;
    op.first_key = pick_key();
    op.second_key = pick_key();
    op.payload = $urandom;
    op.lookup_key = pick_key();
    op.key_space = 1'($urandom_range(0, 1));
    op.delete_one = 1'($urandom_range(0, 1));
    op.version_wanted = ($urandom_range(0, 7) == 0) ? VER_W'($urandom) :
                        VER_W'($urandom_range(0, 3));
    return op;
  endfunction

  // Operations on an empty table, and the ignored opcode
  task automatic test_empty_table();
    send_op(make_op(KIND_FIND, 15'd0, 15'd0, 32'd0, 1'b0, 1'b0, 5'd0));
    send_op(make_op(KIND_DELETE, 15'd7, 15'd0, 32'd0, 1'b1, 1'b1, 5'd0));
    send_op(make_op(KIND_UNUSED, 15'd1, 15'd2, 32'hFFFF_FFFF, 1'b1, 1'b1, 5'd31));
  endtask

  // Fill with colliding keys and extremes, then overflow
  task automatic test_fill_and_full();
    send_op(make_op(KIND_INSERT, -15'sd10000, 15'd9999, 32'h0, 1'b0, 1'b0, 5'd0));
    send_op(make_op(KIND_INSERT, 15'h3FFF, 15'h4000, 32'hFFFF_FFFF, 1'b0, 1'b0, 5'd0));
    for (int i = 0; i < 15; i++)
      send_op(make_op(KIND_INSERT, key_pool[i % 3], key_pool[i % 2], $urandom,
                      1'b0, 1'b0, 5'd0));
  endtask

  // Multi-match finds in both key spaces, then version and bulk deletes
  task automatic test_find_delete();
    send_op(make_op(KIND_FIND, 15'd3, 15'd0, 32'd0, 1'b0, 1'b0, 5'd0));
    send_op(make_op(KIND_FIND, 15'd19, 15'd0, 32'd0, 1'b1, 1'b0, 5'd0));
    send_op(make_op(KIND_FIND, 15'd1234, 15'd0, 32'd0, 1'b0, 1'b0, 5'd0));
    send_op(make_op(KIND_DELETE, 15'd3, 15'd0, 32'd0, 1'b0, 1'b1, 5'd2));
    send_op(make_op(KIND_DELETE, 15'd3, 15'd0, 32'd0, 1'b1, 1'b1, 5'd20));
    send_op(make_op(KIND_DELETE, 15'd19, 15'd0, 32'd0, 1'b1, 1'b0, 5'd0));
    send_op(make_op(KIND_DELETE, -15'sd13, 15'd0, 32'd0, 1'b0, 1'b0, 5'd0));
    send_op(make_op(KIND_INSERT, 15'd3, 15'd3, 32'h5A5A_A5A5, 1'b0, 1'b0, 5'd0));
    send_op(make_op(KIND_FIND, 15'd3, 15'd0, 32'd0, 1'b0, 1'b0, 5'd0));
  endtask

  // Hold the result side while finds keep arriving
  task automatic test_backpressure();
    hold_request = 1;
    for (int i = 0; i < 6; i++)
      send_op(make_op(KIND_FIND, key_pool[i % 3], 15'd0, 32'd0, 1'(i % 2), 1'b0, 5'd0));
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < 165; i++) send_op(random_op());
  endtask

  // Result side: random stalls, one long hold, and row comparison
  initial begin
    int wait_left;
    int hold_left;
    row_t exp_row;
    wait_left = 0;
    hold_left = 0;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp.valid && rsp.ready) begin
        wait_left = $urandom_range(0, 3);
        if (pending_rows.size() == 0) begin
          $error("result row with nothing expected");
          errors++;
        end else begin
          exp_row = pending_rows.pop_front();
          if (rsp.status !== exp_row.status) begin
            $error("status exp %0d got %0d", exp_row.status, rsp.status); errors++; end
          if (rsp.out_first_key !== exp_row.first_key) begin
            $error("out_first_key exp %0h got %0h", exp_row.first_key, rsp.out_first_key);
            errors++; end
          if (rsp.out_first_version !== exp_row.first_version) begin
            $error("out_first_version exp %0d got %0d", exp_row.first_version,
                   rsp.out_first_version); errors++; end
          if (rsp.out_second_key !== exp_row.second_key) begin
            $error("out_second_key exp %0h got %0h", exp_row.second_key,
                   rsp.out_second_key); errors++; end
          if (rsp.out_second_version !== exp_row.second_version) begin
            $error("out_second_version exp %0d got %0d", exp_row.second_version,
                   rsp.out_second_version); errors++; end
          if (rsp.out_payload !== exp_row.payload) begin
            $error("out_payload exp %0h got %0h", exp_row.payload, rsp.out_payload);
            errors++; end
          if (rsp.out_probe_slot !== exp_row.probe_slot) begin
            $error("out_probe_slot exp %0d got %0d", exp_row.probe_slot,
                   rsp.out_probe_slot); errors++; end
          if (rsp.out_chain_slot !== exp_row.chain_slot) begin
            $error("out_chain_slot exp %0d got %0d", exp_row.chain_slot,
                   rsp.out_chain_slot); errors++; end
          if (rsp.last !== exp_row.last) begin
            $error("last exp %0d got %0d", exp_row.last, rsp.last); errors++; end
        end
      end else if (wait_left > 0) begin
        wait_left--;
      end
      if (hold_request) begin
        hold_request = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) hold_left--;
      rsp.ready <= (hold_left == 0) && (wait_left == 0);
    end
  end

  // Watchdog on cycles without any transfer
  initial begin
    forever begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      sh_mark[i] = MARK_EMPTY;
      sh_fkey[i] = '0; sh_skey[i] = '0; sh_fver[i] = '0; sh_sver[i] = '0; sh_pay[i] = '0;
      sh_link[i] = SLOTS;
      sh_head[i] = SLOTS;
    end
    sh_live = 0;
    req.valid = 1'b0;
    req.kind = KIND_FIND;
    req.first_key = '0; req.second_key = '0; req.payload = '0; req.lookup_key = '0;
    req.key_space = 1'b0; req.delete_one = 1'b0; req.version_wanted = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_fill_and_full();
    test_find_delete();
    test_backpressure();
    test_random_mix();
    req.valid <= 1'b0;

    // drain, then allow for trailing activity
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
